/* rtl/bsdfpu_pkg.sv */
// Shared constants, types and microcode for the scheduler fixed-point unit.
// Holds the 17.14 constants, the control word layout and the control store.
// Depends on nothing.
package bsdfpu_pkg;

   localparam int FRACTION_BITS = 14;
   localparam int MAX_PRIORITY  = 63;
   localparam int MIN_PRIORITY  = 0;

   localparam logic signed [31:0] FP_ONE   = 32'(1 << FRACTION_BITS);
   localparam logic signed [31:0] LOAD_C59 = 32'((59 * (1 << FRACTION_BITS)) / 60);
   localparam logic signed [31:0] LOAD_C1  = 32'((1 << FRACTION_BITS) / 60);
   localparam logic signed [31:0] X100     = 32'sd100;
   localparam logic signed [31:0] PRIO_TOP = 32'(MAX_PRIORITY * (1 << FRACTION_BITS));
   localparam logic signed [31:0] PRIO_HI  = 32'(MAX_PRIORITY);
   localparam logic signed [31:0] PRIO_LO  = 32'(MIN_PRIORITY);

   // divider: 32-bit value scaled up by the fraction, two quotient bits a cycle
   localparam int DIV_N_BITS  = 32 + FRACTION_BITS;
   localparam int DIV_CYCLES  = DIV_N_BITS / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_DECAY = 2'd2;
   localparam logic [1:0] FUNC_PRIO  = 2'd3;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [3:0]        uop_type;
   typedef logic [1:0]        jump_type;

   localparam uop_type UOP_TICK      = 4'd0;
   localparam uop_type UOP_MUL_LA59  = 4'd1;
   localparam uop_type UOP_SCALE     = 4'd2;
   localparam uop_type UOP_LOAD_SUM  = 4'd3;
   localparam uop_type UOP_DIV_START = 4'd4;
   localparam uop_type UOP_DIV_TAKE  = 4'd5;
   localparam uop_type UOP_MUL_RC    = 4'd6;
   localparam uop_type UOP_ADD_NICE  = 4'd7;
   localparam uop_type UOP_QUARTER   = 4'd8;
   localparam uop_type UOP_PRIO_X    = 4'd9;
   localparam uop_type UOP_PRIO_RND  = 4'd10;
   localparam uop_type UOP_MUL_LA100 = 4'd11;
   localparam uop_type UOP_RND_LA    = 4'd12;
   localparam uop_type UOP_MUL_RC100 = 4'd13;
   localparam uop_type UOP_RND_RC    = 4'd14;
   localparam uop_type UOP_FINISH    = 4'd15;

   localparam jump_type JMP_NONE   = 2'd0;
   localparam jump_type JMP_ALWAYS = 2'd1;
   localparam jump_type JMP_IDLE   = 2'd2;

   localparam step_type ST_TICK  = 5'd0;
   localparam step_type ST_LOAD  = 5'd1;
   localparam step_type ST_DECAY = 5'd4;
   localparam step_type ST_PRIO  = 5'd9;
   localparam step_type ST_TAIL  = 5'd12;

   typedef struct packed {
      uop_type  op;
      jump_type jump;
      step_type target;
      logic     wait_div;
   } uword_type;

   typedef struct packed {
      logic    run;
      uop_type op;
   } ctl_type;

   function automatic uword_type ucode_rom(input step_type s);
      uword_type w;
      case (s)
         5'd0:    w = '{UOP_TICK,      JMP_ALWAYS, ST_TAIL, 1'b0};
         5'd1:    w = '{UOP_MUL_LA59,  JMP_NONE,   ST_TICK, 1'b0};
         5'd2:    w = '{UOP_SCALE,     JMP_NONE,   ST_TICK, 1'b0};
         5'd3:    w = '{UOP_LOAD_SUM,  JMP_ALWAYS, ST_TAIL, 1'b0};
         5'd4:    w = '{UOP_DIV_START, JMP_IDLE,   ST_TAIL, 1'b0};
         5'd5:    w = '{UOP_DIV_TAKE,  JMP_NONE,   ST_TICK, 1'b1};
         5'd6:    w = '{UOP_MUL_RC,    JMP_NONE,   ST_TICK, 1'b0};
         5'd7:    w = '{UOP_SCALE,     JMP_NONE,   ST_TICK, 1'b0};
         5'd8:    w = '{UOP_ADD_NICE,  JMP_ALWAYS, ST_TAIL, 1'b0};
         5'd9:    w = '{UOP_QUARTER,   JMP_NONE,   ST_TICK, 1'b0};
         5'd10:   w = '{UOP_PRIO_X,    JMP_NONE,   ST_TICK, 1'b0};
         5'd11:   w = '{UOP_PRIO_RND,  JMP_NONE,   ST_TICK, 1'b0};
         5'd12:   w = '{UOP_MUL_LA100, JMP_NONE,   ST_TICK, 1'b0};
         5'd13:   w = '{UOP_RND_LA,    JMP_NONE,   ST_TICK, 1'b0};
         5'd14:   w = '{UOP_MUL_RC100, JMP_NONE,   ST_TICK, 1'b0};
         5'd15:   w = '{UOP_RND_RC,    JMP_NONE,   ST_TICK, 1'b0};
         default: w = '{UOP_FINISH,    JMP_NONE,   ST_TICK, 1'b0};
      endcase
      return w;
   endfunction

   function automatic step_type entry_step(input logic [1:0] f);
      step_type s;
      case (f)
         FUNC_TICK:  s = ST_TICK;
         FUNC_LOAD:  s = ST_LOAD;
         FUNC_DECAY: s = ST_DECAY;
         FUNC_PRIO:  s = ST_PRIO;
         default:    s = ST_TICK;
      endcase
      return s;
   endfunction

   // round 17.14 to nearest integer, halves away from zero
   function automatic logic signed [31:0] round14(input logic signed [31:0] x);
      logic signed [32:0] v;
      v = $signed({x[31], x}) + (x[31] ? 33'sd8191 : 33'sd8192);
      return 32'(v >>> FRACTION_BITS);
   endfunction

endpackage

/* rtl/bsdfpu_div.sv */
// Iterative signed divider, truncating toward zero, two quotient bits a cycle.
// Returns the low 32 quotient bits, or zero for a zero divisor.
// Depends on bsdfpu_pkg.
module bsdfpu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [bsdfpu_pkg::DIV_N_BITS-1:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import bsdfpu_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [31:0]           den_ff, den_in;
   logic [31:0]           rem_ff, rem_in;
   logic [DIV_N_BITS-1:0] quo_ff, quo_in;

   always_comb begin
      logic [32:0]           sh;
      logic [31:0]           r;
      logic [DIV_N_BITS-1:0] q;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < 2; i++) begin
         sh = {r, q[DIV_N_BITS-1]};
         if (sh >= {1'b0, den_ff}) begin
            r = 32'(sh - {1'b0, den_ff});
            q = {q[DIV_N_BITS-2:0], 1'b1};
         end else begin
            r = sh[31:0];
            q = {q[DIV_N_BITS-2:0], 1'b0};
         end
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_CYCLES - 1);
         neg_in  = dividend[DIV_N_BITS-1] ^ divisor[31];
         zero_in = (divisor == 32'd0);
         den_in  = divisor[31] ? (~divisor + 32'd1) : divisor;
         quo_in  = dividend[DIV_N_BITS-1] ? (~dividend + DIV_N_BITS'(1)) : dividend;
         rem_in  = 32'd0;
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = q;
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done     = !busy_ff;
   assign quotient = zero_ff ? 32'd0 : (neg_ff ? (~quo_ff[31:0] + 32'd1) : quo_ff[31:0]);

endmodule

/* rtl/bsdfpu_seq.sv */
// Microcode sequencer: step counter, control store fetch, jumps and result handshake.
// Depends on bsdfpu_pkg.
module bsdfpu_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_func,
   input  logic                 rsp_stall,
   input  logic                 idle,
   input  logic                 div_done,
   output logic                 req_stall,
   output logic                 rsp_valid,
   output bsdfpu_pkg::ctl_type  ctl
);
   import bsdfpu_pkg::*;

   logic      busy_ff, busy_in;
   step_type  step_ff, step_in;
   logic      rsp_valid_ff, rsp_valid_in;
   uword_type uw;
   logic      hold, issue, taken, finish, req_fire;

   assign uw       = ucode_rom(step_ff);
   assign finish   = (uw.op == UOP_FINISH);
   assign hold     = (uw.wait_div && !div_done) || (finish && rsp_valid_ff && rsp_stall);
   assign issue    = busy_ff && !hold;
   assign taken    = (uw.jump == JMP_ALWAYS) || ((uw.jump == JMP_IDLE) && idle);
   assign req_fire = req_valid && !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
         step_in = entry_step(req_func);
      end else if (issue) begin
         if (finish) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if (taken) begin
            step_in = uw.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign ctl       = '{run: issue, op: uw.op};

endmodule

/* rtl/bsdfpu_dp.sv */
// Datapath: request registers, load average, shared multiplier and work registers.
// Executes one micro-operation per issued step; feeds the divider.
// Depends on bsdfpu_pkg.
module bsdfpu_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  bsdfpu_pkg::ctl_type   ctl,
   input  logic                  req_fire,
   input  logic signed [31:0]    req_recent_cpu_in,
   input  logic signed [5:0]     req_nice_value,
   input  logic [6:0]            req_ready_count,
   input  logic                  req_is_idle,
   input  logic [31:0]           div_quotient,
   output logic                  div_start,
   output logic [bsdfpu_pkg::DIV_N_BITS-1:0] div_dividend,
   output logic [31:0]           div_divisor,
   output logic                  idle,
   output logic signed [31:0]    rsp_recent_cpu_out,
   output logic [5:0]            rsp_priority_out,
   output logic signed [31:0]    rsp_load_fixed,
   output logic signed [31:0]    rsp_load_x100,
   output logic signed [31:0]    rsp_recent_x100
);
   import bsdfpu_pkg::*;

   localparam int SC_W = 32 + FRACTION_BITS;

   logic signed [31:0] rc_ff, rc_in;
   logic signed [5:0]  nice_ff, nice_in;
   logic [6:0]         ready_ff, ready_in;
   logic               idle_ff, idle_in;
   logic signed [31:0] la_ff, la_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [63:0] p_ff, p_in;
   logic [5:0]         prio_ff, prio_in;
   logic signed [31:0] lx_ff, lx_in;
   logic signed [31:0] rx_ff, rx_in;
   logic signed [31:0] o_rc_ff, o_la_ff, o_lx_ff, o_rx_ff;
   logic [5:0]         o_prio_ff;
   logic               o_load;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic [SC_W-1:0]    sc_sum;
   logic signed [31:0] scaled;
   logic signed [31:0] nice_ext;
   logic signed [31:0] ready_fp;
   logic signed [31:0] q_sum, quarter;
   logic signed [31:0] pr_round, pr_clamp;
   logic signed [31:0] two_la;

   assign mul_p    = mul_a * mul_b;
   assign sc_sum   = p_ff[SC_W-1:0] + (p_ff[63] ? SC_W'((1 << FRACTION_BITS) - 1) : SC_W'(0));
   assign scaled   = sc_sum[SC_W-1:FRACTION_BITS];
   assign nice_ext = 32'(nice_ff);
   assign ready_fp = LOAD_C1 * $signed({25'd0, ready_ff});
   assign q_sum    = rc_ff + (rc_ff[31] ? 32'sd3 : 32'sd0);
   assign quarter  = q_sum >>> 2;
   assign pr_round = round14(t_ff);
   assign pr_clamp = (pr_round < PRIO_LO) ? PRIO_LO : ((pr_round > PRIO_HI) ? PRIO_HI : pr_round);
   assign two_la   = la_ff <<< 1;

   assign div_start    = ctl.run && (ctl.op == UOP_DIV_START);
   assign div_dividend = {two_la, {FRACTION_BITS{1'b0}}};
   assign div_divisor  = two_la + FP_ONE;
   assign o_load       = ctl.run && (ctl.op == UOP_FINISH);

   always_comb begin
      mul_a = la_ff;
      mul_b = LOAD_C59;
      case (ctl.op)
         UOP_MUL_RC: begin
            mul_a = t_ff;
            mul_b = rc_ff;
         end
         UOP_MUL_LA100: begin
            mul_a = la_ff;
            mul_b = X100;
         end
         UOP_MUL_RC100: begin
            mul_a = rc_ff;
            mul_b = X100;
         end
         default: begin
            mul_a = la_ff;
            mul_b = LOAD_C59;
         end
      endcase
   end

   always_comb begin
      rc_in    = rc_ff;
      nice_in  = nice_ff;
      ready_in = ready_ff;
      idle_in  = idle_ff;
      la_in    = la_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      prio_in  = prio_ff;
      lx_in    = lx_ff;
      rx_in    = rx_ff;
      if (req_fire) begin
         rc_in    = req_recent_cpu_in;
         nice_in  = req_nice_value;
         ready_in = req_ready_count;
         idle_in  = req_is_idle;
         prio_in  = 6'd0;
      end else if (ctl.run) begin
         case (ctl.op)
            UOP_TICK: begin
               if (!idle_ff) begin
                  rc_in = rc_ff + FP_ONE;
               end
            end
            UOP_MUL_LA59, UOP_MUL_RC, UOP_MUL_LA100, UOP_MUL_RC100: begin
               p_in = mul_p;
            end
            UOP_SCALE:    t_in  = scaled;
            UOP_LOAD_SUM: la_in = t_ff + ready_fp;
            UOP_DIV_TAKE: t_in  = $signed(div_quotient);
            UOP_ADD_NICE: rc_in = t_ff + (nice_ext <<< FRACTION_BITS);
            UOP_QUARTER:  t_in  = quarter;
            UOP_PRIO_X:   t_in  = PRIO_TOP - t_ff - (nice_ext <<< (FRACTION_BITS + 1));
            UOP_PRIO_RND: prio_in = pr_clamp[5:0];
            UOP_RND_LA:   lx_in = round14(p_ff[31:0]);
            UOP_RND_RC:   rx_in = round14(p_ff[31:0]);
            default: begin
               t_in = t_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         la_ff <= 32'sd0;
      end else begin
         la_ff <= la_in;
      end
      rc_ff    <= rc_in;
      nice_ff  <= nice_in;
      ready_ff <= ready_in;
      idle_ff  <= idle_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      prio_ff  <= prio_in;
      lx_ff    <= lx_in;
      rx_ff    <= rx_in;
      if (o_load) begin
         o_rc_ff   <= rc_ff;
         o_prio_ff <= prio_ff;
         o_la_ff   <= la_ff;
         o_lx_ff   <= lx_ff;
         o_rx_ff   <= rx_ff;
      end
   end

   assign idle               = idle_ff;
   assign rsp_recent_cpu_out = o_rc_ff;
   assign rsp_priority_out   = o_prio_ff;
   assign rsp_load_fixed     = o_la_ff;
   assign rsp_load_x100      = o_lx_ff;
   assign rsp_recent_x100    = o_rx_ff;

endmodule

/* rtl/bsd_scheduler_fixed_point_unit.sv */
// Top level of the 17.14 scheduler fixed-point unit.
// Instantiates bsdfpu_seq, bsdfpu_dp and bsdfpu_div; depends on bsdfpu_pkg.
//
//   channel  handshake             payload
//   req      req_valid/req_stall   func, recent_cpu_in, nice_value, ready_count, is_idle
//   rsp      rsp_valid/rsp_stall   recent_cpu_out, priority_out, load_fixed,
//                                  load_x100, recent_x100
//
// One request at a time; req_stall is high from accept until the microprogram ends.
// Decay waits for the two-bit-per-cycle divider unless is_idle is set, in which case
// it skips to the common tail; each use of the shared multiplier is a step of its own.
// A finished result sits in the output register, so a new request is taken while
// rsp_stall holds it; the program waits at its last step only if a second result is due.
// Synchronous reset clears the load average and all control state.
module bsd_scheduler_fixed_point_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_recent_cpu_in,
   input  logic signed [5:0]  req_nice_value,
   input  logic [6:0]         req_ready_count,
   input  logic               req_is_idle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_recent_cpu_out,
   output logic [5:0]         rsp_priority_out,
   output logic signed [31:0] rsp_load_fixed,
   output logic signed [31:0] rsp_load_x100,
   output logic signed [31:0] rsp_recent_x100
);
   import bsdfpu_pkg::*;

   ctl_type               ctl;
   logic                  idle;
   logic                  div_start, div_done;
   logic [DIV_N_BITS-1:0] div_dividend;
   logic [31:0]           div_divisor, div_quotient;
   logic                  req_fire;

   assign req_fire = req_valid && !req_stall;

   bsdfpu_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .rsp_stall (rsp_stall),
      .idle      (idle),
      .div_done  (div_done),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   bsdfpu_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_fire           (req_fire),
      .req_recent_cpu_in  (req_recent_cpu_in),
      .req_nice_value     (req_nice_value),
      .req_ready_count    (req_ready_count),
      .req_is_idle        (req_is_idle),
      .div_quotient       (div_quotient),
      .div_start          (div_start),
      .div_dividend       (div_dividend),
      .div_divisor        (div_divisor),
      .idle               (idle),
      .rsp_recent_cpu_out (rsp_recent_cpu_out),
      .rsp_priority_out   (rsp_priority_out),
      .rsp_load_fixed     (rsp_load_fixed),
      .rsp_load_x100      (rsp_load_x100),
      .rsp_recent_x100    (rsp_recent_x100)
   );

   bsdfpu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for bsd_scheduler_fixed_point_unit: directed and random requests on
// every function, checked against a 17.14 load, CPU usage and priority predictor.
// Depends on bsdfpu_pkg and the unit's RTL.
module tb_top;
   import bsdfpu_pkg::*;

   localparam longint FP_SCALE     = 64'sd1 << FRACTION_BITS;
   localparam longint FP_HALF      = FP_SCALE / 2;
   localparam int     RANDOM_ITEMS = 1750;
   localparam int     DRAIN_CYCLES = 100;
   localparam int     CYCLE_LIMIT  = 1000000;
   localparam int     LONG_HOLD    = 400;

   typedef struct {
      logic signed [31:0] rc_next;
      logic [5:0]         prio;
      logic signed [31:0] load_fixed;
      logic signed [31:0] load_x100;
      logic signed [31:0] recent_x100;
   } sched_result_type;

   class fpu_scoreboard;
      sched_result_type   results_due[$];
      logic signed [31:0] la_model;
      int                 errors;

      function new();
         la_model = '0;
         errors   = 0;
      endfunction

      function int round_fixed(int x);
         longint v;
         v = x;
         if (v >= 0)
            return int'((v + FP_HALF) / FP_SCALE);
         return int'((v - FP_HALF) / FP_SCALE);
      endfunction

      function int scale_x100(int x);
         int p;
         p = int'(longint'(x) * 100);
         return round_fixed(p);
      endfunction

      function void note_request(logic [1:0] func, logic signed [31:0] rc,
                                 logic signed [5:0] nice, logic [6:0] ready, logic idle);
         sched_result_type r;
         int               rc_out, two, den, d, prod, first, second, x, p;
         longint           quarter;
         rc_out = rc;
         p      = 0;
         case (func)
            FUNC_TICK: begin
               if (!idle)
                  rc_out = int'(longint'(rc) + FP_SCALE);
            end
            FUNC_LOAD: begin
               first    = int'(((59 * FP_SCALE) / 60 * longint'(la_model)) / FP_SCALE);
               second   = int'((FP_SCALE / 60) * longint'(ready));
               la_model = int'(longint'(first) + longint'(second));
            end
            FUNC_DECAY: begin
               if (!idle) begin
                  two = int'(longint'(la_model) * 2);
                  den = int'(longint'(two) + FP_SCALE);
                  if (den == 0)
                     d = 0;
                  else
                     d = int'((longint'(two) * FP_SCALE) / longint'(den));
                  prod   = int'((longint'(d) * longint'(rc)) / FP_SCALE);
                  rc_out = int'(longint'(prod) + longint'(nice) * FP_SCALE);
               end
            end
            default: begin
               quarter = longint'(rc) / 4;
               x = int'(longint'(MAX_PRIORITY) * FP_SCALE - quarter
                        - longint'(nice) * 2 * FP_SCALE);
               p = round_fixed(x);
               if (p < MIN_PRIORITY)
                  p = MIN_PRIORITY;
               else if (p > MAX_PRIORITY)
                  p = MAX_PRIORITY;
            end
         endcase
         r.rc_next     = rc_out;
         r.prio        = 6'(p);
         r.load_fixed  = la_model;
         r.load_x100   = scale_x100(la_model);
         r.recent_x100 = scale_x100(rc_out);
         results_due.push_back(r);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d (%h), got %0d (%h)",
                     $time, name, want, want, got, got);
         end
      endfunction

      function void check_result(logic signed [31:0] rc_out, logic [5:0] prio,
                                 logic signed [31:0] la, logic signed [31:0] la100,
                                 logic signed [31:0] rc100);
         sched_result_type r;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: result with no request pending, recent_cpu_out %h",
                     $time, rc_out);
            return;
         end
         r = results_due.pop_front();
         compare_field("recent_cpu_out", r.rc_next, rc_out);
         compare_field("priority_out", {26'b0, r.prio}, {26'b0, prio});
         compare_field("load_fixed", r.load_fixed, la);
         compare_field("load_x100", r.load_x100, la100);
         compare_field("recent_x100", r.recent_x100, rc100);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_TICK;
   logic signed [31:0] req_recent_cpu_in = '0;
   logic signed [5:0]  req_nice_value = '0;
   logic [6:0]         req_ready_count = '0;
   logic               req_is_idle = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_recent_cpu_out;
   logic [5:0]         rsp_priority_out;
   logic signed [31:0] rsp_load_fixed;
   logic signed [31:0] rsp_load_x100;
   logic signed [31:0] rsp_recent_x100;

   fpu_scoreboard fpu_ledger = new();
   int            cycle_count = 0;
   int            tx_calm = 0;

   bsd_scheduler_fixed_point_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_recent_cpu_in  (req_recent_cpu_in),
      .req_nice_value     (req_nice_value),
      .req_ready_count    (req_ready_count),
      .req_is_idle        (req_is_idle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_recent_cpu_out (rsp_recent_cpu_out),
      .rsp_priority_out   (rsp_priority_out),
      .rsp_load_fixed     (rsp_load_fixed),
      .rsp_load_x100      (rsp_load_x100),
      .rsp_recent_x100    (rsp_recent_x100)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            fpu_ledger.note_request(req_func, req_recent_cpu_in, req_nice_value,
                                    req_ready_count, req_is_idle);
         if (rsp_valid && !rsp_stall)
            fpu_ledger.check_result(rsp_recent_cpu_out, rsp_priority_out, rsp_load_fixed,
                                    rsp_load_x100, rsp_recent_x100);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic [1:0] func, input logic signed [31:0] rc,
                               input logic signed [5:0] nice, input logic [6:0] ready,
                               input logic idle);
      int gap;
      req_func          <= func;
      req_recent_cpu_in <= rc;
      req_nice_value    <= nice;
      req_ready_count   <= ready;
      req_is_idle       <= idle;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (tx_calm > 0) begin
         tx_calm--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0)
            tx_calm = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_request();
      logic signed [31:0] rc;
      logic signed [5:0]  nice;
      logic [6:0]         ready;
      logic [1:0]         func;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         func = FUNC_TICK;
      else if (pick < 45)
         func = FUNC_LOAD;
      else if (pick < 70)
         func = FUNC_DECAY;
      else
         func = FUNC_PRIO;
      case ($urandom_range(0, 9))
         0, 1, 2: rc = $urandom_range(0, 300 << FRACTION_BITS);
         3, 4:    rc = -$signed($urandom_range(0, 100 << FRACTION_BITS));
         5, 6:    rc = $urandom();
         7: begin
            case ($urandom_range(0, 3))
               0:       rc = 32'sh7FFFFFFF;
               1:       rc = 32'sh80000000;
               2:       rc = 32'sh7FFFC000;
               default: rc = -32'sd1;
            endcase
         end
         default: rc = $signed($urandom_range(0, 1 << 16)) - 32'sd32768;
      endcase
      if ($urandom_range(0, 4) == 0)
         nice = 6'($urandom());
      else
         nice = 6'($signed($urandom_range(0, 40)) - 32'sd20);
      if ($urandom_range(0, 4) == 0)
         ready = 7'($urandom());
      else
         ready = 7'($urandom_range(0, 64));
      send_request(func, rc, nice, ready, $urandom_range(0, 7) == 0);
   endtask

   initial begin : rsp_side
      int rounds, hold, run;
      rounds = 0;
      @(posedge clock iff !reset);
      forever begin
         rounds++;
         if (rounds % 600 == 150)
            hold = LONG_HOLD;
         else
            hold = pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            run = $urandom_range(20, 120);
         else
            run = $urandom_range(1, 6);
         repeat (run) @(posedge clock);
      end
   end

   initial begin : req_side
      int         sent, burst;
      logic [6:0] burst_ready;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(FUNC_TICK, 32'sd0, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_TICK, 32'sh7FFFFFFF, 6'sd31, 7'd127, 1'b0);
      send_request(FUNC_TICK, 32'sh00012345, 6'sb100000, 7'd0, 1'b1);
      send_request(FUNC_TICK, 32'sh7FFF0000, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sd0, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sh80000000, 6'sb100000, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sh7FFFFFFF, 6'sd31, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sd2064384, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sd4161536, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sd1638400, 6'sd20, 7'd0, 1'b0);
      send_request(FUNC_PRIO, 32'sd49152, -6'sd20, 7'd0, 1'b0);
      send_request(FUNC_DECAY, 32'sh7FFFFFFF, 6'sb100000, 7'd0, 1'b0);
      send_request(FUNC_DECAY, 32'sd81920, 6'sd3, 7'd0, 1'b1);
      send_request(FUNC_LOAD, 32'sd0, 6'sd0, 7'd127, 1'b0);
      send_request(FUNC_LOAD, 32'sd0, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_LOAD, 32'sd0, 6'sd0, 7'd64, 1'b0);
      send_request(FUNC_LOAD, 32'shFFFFFFFF, 6'sd31, 7'd127, 1'b1);
      send_request(FUNC_LOAD, 32'sd0, 6'sd0, 7'd127, 1'b0);
      send_request(FUNC_DECAY, 32'sh80000000, 6'sd31, 7'd0, 1'b0);
      send_request(FUNC_DECAY, 32'sd819200, -6'sd20, 7'd0, 1'b0);
      send_request(FUNC_DECAY, 32'sh7FFFFFFF, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_PRIO, -32'sd114688, 6'sd0, 7'd0, 1'b0);
      send_request(FUNC_TICK, 32'sh80000000, 6'sd0, 7'd0, 1'b0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(5, 25);
            burst_ready = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(65, 127))
                                                      : 7'($urandom_range(0, 64));
            repeat (burst) begin
               send_request(FUNC_LOAD, $urandom(), 6'($urandom()), burst_ready,
                            1'($urandom_range(0, 1)));
               sent++;
            end
         end else begin
            send_random_request();
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (fpu_ledger.results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fpu_ledger.errors == 0 && fpu_ledger.results_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
